// ===== design/le_pkg.sv =====
// shared constants, payload types and state codes of the label entropy block
`default_nettype none

package le_pkg;

  // configuration
  localparam int NUM_CLASSES = 16;
  localparam int COUNT_BITS  = 16;

  // fixed field widths
  localparam int LABEL_W = 4;
  localparam int ENT_W   = 19;
  localparam int TOTAL_W = 16;

  // log2 format: integer part in the top bits, LOG_FRAC fraction bits
  localparam int LOG_FRAC  = 24;
  localparam int NORM_BITS = 30;
  localparam int LOG_E_W   = 5;
  localparam int LOG_W     = LOG_E_W + LOG_FRAC;

  // derived widths
  localparam int CLS_W  = $clog2(NUM_CLASSES);
  localparam int PROD_W = COUNT_BITS + LOG_W;
  localparam int ACC_W  = PROD_W + CLS_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int DEN_W  = COUNT_BITS + 8;

  localparam logic [ENT_W-1:0]   ENT_MAX   = {ENT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef logic [CLS_W-1:0]      cls_idx_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [LOG_W-1:0]      log_t;

  typedef struct packed {
    logic [LABEL_W-1:0] class_label;
    logic               last_item;
  } le_in_t;

  typedef struct packed {
    logic [ENT_W-1:0]   entropy_value;
    logic [TOTAL_W-1:0] sample_total;
    logic               count_overflow;
  } le_out_t;

  // histogram requests from the sequencer
  typedef struct packed {
    logic     upd;
    logic     rd;
    logic     clr;
    cls_idx_t idx;
  } hist_ctrl_t;

  typedef enum logic [3:0] {
    S_COUNT,
    S_DRAIN,
    S_READ,
    S_LOAD,
    S_LOG,
    S_MUL,
    S_ACC,
    S_DIFF,
    S_DIVGO,
    S_DIV,
    S_DONE
  } le_state_e;

endpackage

`default_nettype wire

// ===== design/label_entropy.sv =====
// top level: class label histogram with shannon entropy at the end of each set
//
// input channel: one class label per transfer, with a flag on the final label
// of a set. labels are taken back to back, one per cycle, while a set is being
// counted; a label at or above NUM_CLASSES is ignored apart from its flag.
// once the running total reaches its maximum further labels are dropped and
// the overflow flag of the set is raised.
// after the final label the input stalls for the entropy pass: each class
// count is read from the histogram ram, its log2 formed by the squaring unit,
// multiplied and summed; the set size then goes through the same log2 and
// multiply, then a restoring divide of one bit per cycle.
// the result goes to an output register; a stalled receiver holds it, and the
// next set may already be counted behind it. a second final label waits in
// the pass until the output register is free.
// reset: histogram valid bits, total and overflow flag clear at once, so the
// block takes labels in the first cycle after reset. the same clear happens
// when a result is loaded.
`default_nettype none

module label_entropy import le_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire le_in_t  in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output le_out_t      out_data_o
);

  localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

  le_state_e        state_q;
  le_state_e        state_d;

  count_t           total_q;
  logic             ovf_q;
  logic             phase_q;       // 0: class sweep, 1: set size
  cls_idx_t         k_q;
  count_t           x_q;
  logic [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0] acc_q;
  logic [PROD_W-1:0] diff_q;
  logic             out_vld_q;
  le_out_t          out_q;

  hist_ctrl_t       hctrl;
  count_t           hist_count;
  count_t           x_sel;
  logic             log_start;
  logic             log_done;
  log_t             log_val;
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] quo;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;

  logic             accept;
  logic             in_range;
  logic             set_full;
  logic             out_free;
  logic             load_out;
  logic             k_last;
  logic [PROD_W-1:0] prod_d;
  logic [ACC_W-1:0] whole_ext;
  le_out_t          res;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_range = 32'(in_data_i.class_label) < 32'(NUM_CLASSES);
  assign set_full = (total_q == COUNT_MAX);
  assign out_free = !out_vld_q || !out_stall_i;
  assign k_last   = (k_q == CLS_W'(NUM_CLASSES - 1));
  assign x_sel    = phase_q ? total_q : hist_count;

  le_hist u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (hctrl),
    .count_o(hist_count)
  );

  le_log2 u_log2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(log_start),
    .x_i    (x_sel),
    .done_o (log_done),
    .log_o  (log_val)
  );

  // rounded divide: (d + n * 2^7) / (n * 2^8)
  assign div_num = NUM_W'(diff_q) + (NUM_W'(total_q) << 7);
  assign div_den = DEN_W'(total_q) << 8;

  le_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_COUNT: if (accept && in_data_i.last_item) state_d = S_DRAIN;
      S_DRAIN: state_d = S_READ;
      S_READ:  state_d = S_LOAD;
      S_LOAD:  state_d = S_LOG;
      S_LOG:   if (log_done) state_d = S_MUL;
      S_MUL:   state_d = S_ACC;
      S_ACC: begin
        if (phase_q) begin
          state_d = S_DIFF;
        end else if (k_last) begin
          state_d = S_LOAD;
        end else begin
          state_d = S_READ;
        end
      end
      S_DIFF:  state_d = S_DIVGO;
      S_DIVGO: state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_COUNT;
      default: state_d = S_COUNT;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o = 1'b1;
    hctrl      = '0;
    log_start  = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      S_COUNT: begin
        // input is never stalled while counting
        in_stall_o = 1'b0;
        hctrl.upd  = in_valid_i && in_range && !set_full;
        hctrl.idx  = CLS_W'(in_data_i.class_label);
      end
      S_READ: begin
        hctrl.rd  = 1'b1;
        hctrl.idx = k_q;
      end
      S_LOAD:  log_start = 1'b1;
      S_DIVGO: div_start = 1'b1;
      S_DONE: begin
        hctrl.clr = out_free;
        load_out  = out_free;
      end
      default: ;
    endcase
  end

  assign prod_d    = PROD_W'(x_q) * PROD_W'(log_val);
  assign whole_ext = ACC_W'(prod_q);

  // result fields with saturation; an empty set gives zero
  always_comb begin
    if (total_q == '0) begin
      res.entropy_value = '0;
    end else if (quo > NUM_W'(ENT_MAX)) begin
      res.entropy_value = ENT_MAX;
    end else begin
      res.entropy_value = quo[ENT_W-1:0];
    end
    if (33'(total_q) > 33'(TOTAL_MAX)) begin
      res.sample_total = TOTAL_MAX;
    end else begin
      res.sample_total = TOTAL_W'(total_q);
    end
    res.count_overflow = ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_COUNT;
      total_q   <= '0;
      ovf_q     <= 1'b0;
      phase_q   <= 1'b0;
      k_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_COUNT: begin
          if (accept && in_range) begin
            if (set_full) begin
              ovf_q <= 1'b1;
            end else begin
              total_q <= total_q + count_t'(1);
            end
          end
        end
        S_DRAIN: begin
          phase_q <= 1'b0;
          k_q     <= '0;
        end
        S_ACC: begin
          if (!phase_q) begin
            if (k_last) begin
              phase_q <= 1'b1;
            end else begin
              k_q <= k_q + CLS_W'(1);
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            total_q <= '0;
            ovf_q   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_DRAIN) begin
      acc_q <= '0;
    end
    if (state_q == S_LOAD) begin
      x_q <= x_sel;
    end
    if (state_q == S_MUL) begin
      prod_q <= prod_d;
    end
    if ((state_q == S_ACC) && !phase_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (state_q == S_DIFF) begin
      // n * log2(n) minus the class terms, floored at zero
      diff_q <= (acc_q > whole_ext) ? '0 : PROD_W'(whole_ext - acc_q);
    end
    if (load_out) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== design/le_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none

module le_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/le_hist.sv =====
// class histogram: read-modify-write counter update over a ram with forwarding
`default_nettype none

module le_hist import le_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire hist_ctrl_t ctrl_i,
  output count_t          count_o
);

  logic [NUM_CLASSES-1:0] valid_q;
  logic                   s1_vld_q;
  cls_idx_t               s1_idx_q;
  cls_idx_t               rd_idx_q;
  logic                   wr_vld_q;
  cls_idx_t               wr_idx_q;
  count_t                 wr_val_q;
  count_t                 rdata;
  count_t                 base;
  count_t                 new_val;

  le_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(NUM_CLASSES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (s1_vld_q),
    .waddr_i(s1_idx_q),
    .wdata_i(new_val),
    .re_i   (ctrl_i.upd | ctrl_i.rd),
    .raddr_i(ctrl_i.idx),
    .rdata_o(rdata)
  );

  // write of the previous cycle is not yet in the read data
  always_comb begin
    if (wr_vld_q && (wr_idx_q == s1_idx_q)) begin
      base = wr_val_q;
    end else if (valid_q[s1_idx_q]) begin
      base = rdata;
    end else begin
      base = '0;
    end
    new_val = base + count_t'(1);
  end

  assign count_o = valid_q[rd_idx_q] ? rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      s1_vld_q <= 1'b0;
      wr_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= ctrl_i.upd;
      wr_vld_q <= s1_vld_q;
      if (ctrl_i.clr) begin
        valid_q <= '0;
      end else if (s1_vld_q) begin
        valid_q[s1_idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd) begin
      s1_idx_q <= ctrl_i.idx;
    end
    if (ctrl_i.rd) begin
      rd_idx_q <= ctrl_i.idx;
    end
    if (s1_vld_q) begin
      wr_idx_q <= s1_idx_q;
      wr_val_q <= new_val;
    end
  end

endmodule

`default_nettype wire

// ===== design/le_log2.sv =====
// iterative fixed-point log2, one squaring per cycle
`default_nettype none

module le_log2 import le_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   start_i,
  input  wire count_t x_i,
  output logic        done_o,
  output log_t        log_o
);

  localparam int CNT_W = $clog2(LOG_FRAC);
  localparam int EXT_W = COUNT_BITS + 32;
  localparam int Y_W   = NORM_BITS + 1;

  logic                busy_q;
  logic                done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [Y_W-1:0]      y_q;
  logic [Y_W-1:0]      y_d;
  logic [LOG_FRAC-1:0] frac_q;
  logic [LOG_E_W-1:0]  e_q;
  logic [LOG_E_W-1:0]  lead;
  logic [EXT_W-1:0]    ext;
  logic [2*Y_W-1:0]    sq;
  logic [Y_W:0]        t;

  // leading one position, zero input gives zero
  always_comb begin
    lead = '0;
    for (int i = 0; i < COUNT_BITS; i++) begin
      if (x_i[i]) begin
        lead = LOG_E_W'(i);
      end
    end
  end

  // place the leading one at bit NORM_BITS
  assign ext = {x_i, 32'd0} >> (6'(lead) + 6'(32 - NORM_BITS));

  always_comb begin
    sq = (2*Y_W)'(y_q) * (2*Y_W)'(y_q);
    t  = sq[2*NORM_BITS+1:NORM_BITS];
    y_d = t[Y_W] ? t[Y_W:1] : t[Y_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(LOG_FRAC - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      e_q    <= lead;
      y_q    <= ext[Y_W-1:0];
      frac_q <= '0;
    end else if (busy_q) begin
      y_q    <= y_d;
      frac_q <= {frac_q[LOG_FRAC-2:0], t[Y_W]};
    end
  end

  assign done_o = done_q;
  assign log_o  = {e_q, frac_q};

endmodule

`default_nettype wire

// ===== design/le_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none

module le_div import le_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             qbit;

  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    diff    = shifted - {1'b0, den_q};
    qbit    = !diff[DEN_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], qbit};
      rem_q <= qbit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire
